@@ src/bitmap_first_free_allocator_unit_assert.svh @@
// Assertion macros used by the allocator sequencer (bfa_ctrl).
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define BFA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ src/bfa_pkg.sv @@
// Types and constants shared by the bitmap allocator modules.
package bfa_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 13;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [CFG_W-1:0] ACTIVE_COUNT_RESET = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ACCESS,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Result fields, status in the lowest bits.
    typedef struct packed {
        logic             bit_read;
        logic [IDX_W-1:0] entry_index;
        status_t          status;
    } result_t;

endpackage

@@ src/bfa_mem.sv @@
// Bitmap word memory: one write port, one read port with registered read data.
module bfa_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bfa_ctrl.sv @@
// Command sequencer: clearing pass, bit access and first-free word scan.
`include "bitmap_first_free_allocator_unit_assert.svh"
module bfa_ctrl #(
    parameter int MAP_BITS  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [bfa_pkg::CFG_W-1:0]            active_count,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [bfa_pkg::CMD_W-1:0]            command,
    input  logic [bfa_pkg::IDX_W-1:0]            bit_index,
    input  logic                                 bit_value,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output bfa_pkg::result_t                     res,
    output logic                                 rd_en,
    output logic [((MAP_BITS + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAP_BITS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] rd_addr,
    input  logic [WORD_BITS-1:0]                 rd_data,
    output logic                                 wr_en,
    output logic [((MAP_BITS + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAP_BITS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] wr_addr,
    output logic [WORD_BITS-1:0]                 wr_data
);

    import bfa_pkg::*;

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WB_LG     = $clog2(WORD_BITS);
    localparam int MAP_CW    = $clog2(MAP_BITS + 1);
    localparam int CNT_W     = (MAP_CW > CFG_W) ? MAP_CW : CFG_W;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              val_reg;
    logic [AW-1:0]     word_reg, word_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0]  n_eff;
    logic [AW-1:0]     last_word;
    logic [WB_LG-1:0]  rem;
    logic              is_last;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic              found;
    logic [WB_LG-1:0]  first_free;
    logic [AW-1:0]     idx_word;
    logic [WB_LG-1:0]  idx_bit;
    logic              range_err;
    logic              accept;

    // Effective count, saturated at the bitmap size.
    always_comb
    begin
        if (CNT_W'(active_count) > CNT_W'(MAP_BITS))
        begin
            n_eff = CNT_W'(MAP_BITS);
        end
        else
        begin
            n_eff = CNT_W'(active_count);
        end
    end

    // Position of the last active word and of the active bits within it.
    assign last_word = AW'((n_eff - CNT_W'(1)) >> WB_LG);
    assign rem       = n_eff[WB_LG-1:0];
    assign is_last   = (word_reg == last_word);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            valid_mask[b] = !is_last || (rem == '0) || (WB_LG'(b) < rem);
        end
    end

    // Lowest clear active bit of the word being scanned.
    assign free_bits = ~rd_data & valid_mask;
    assign found     = |free_bits;

    always_comb
    begin
        first_free = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                first_free = WB_LG'(b);
            end
        end
    end

    // Word and bit of the requested index, and its range check.
    assign idx_word  = AW'(CNT_W'(idx_reg) >> WB_LG);
    assign idx_bit   = idx_reg[WB_LG-1:0];
    assign range_err = (CNT_W'(idx_reg) >= n_eff);
    assign accept    = item_valid && item_ready;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            idx_reg <= bit_index;
            val_reg <= bit_value;
        end
        res_reg <= res_next;
    end

    // Next state, memory accesses and handshakes.
    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = word_reg;
        wr_en      = 1'b0;
        wr_addr    = word_reg;
        wr_data    = rd_data;
        item_ready = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (word_reg == AW'(NUM_WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next.status      = STATUS_OK;
                res_next.entry_index = idx_reg;
                res_next.bit_read    = 1'b0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    res_next.entry_index = '0;
                    if (n_eff == '0)
                    begin
                        res_next.status = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        word_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
                else if (range_err)
                begin
                    res_next.status = STATUS_RANGE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_word;
                    word_next  = idx_word;
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                res_next.bit_read = rd_data[idx_bit];
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en   = 1'b1;
                    wr_data = (rd_data & ~(WORD_BITS'(1) << idx_bit))
                            | (WORD_BITS'(val_reg) << idx_bit);
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    wr_en                = 1'b1;
                    wr_data              = rd_data | (WORD_BITS'(1) << first_free);
                    res_next.status      = STATUS_OK;
                    res_next.entry_index = IDX_W'({word_reg, first_free});
                    state_next           = ST_DONE;
                end
                else if (is_last)
                begin
                    res_next.status = STATUS_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = word_reg + AW'(1);
                    word_next = word_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // The bitmap is only written while clearing, on a write access or on an allocation.
    `BFA_ASSERT(a_write_state, clk, rst_n, wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_SCAN || state_reg == ST_ACCESS), "bitmap written in an unexpected state")
    // A full report carries a zero index and a zero bit.
    `BFA_ASSERT(a_full_fields, clk, rst_n, (state_reg == ST_DONE && res_reg.status == STATUS_FULL) |-> (res_reg.entry_index == '0 && !res_reg.bit_read), "full result carries nonzero fields")
    // An index out of range never reaches the memory.
    `BFA_ASSERT(a_range_no_access, clk, rst_n, (state_reg == ST_EXEC && cmd_reg != CMD_ALLOC && range_err) |-> (!rd_en && !wr_en), "out of range index accessed memory")
    // A scan that misses moves on to the following word.
    `BFA_ASSERT(a_scan_advance, clk, rst_n, (state_reg == ST_SCAN && !found && !is_last) |=> (state_reg == ST_SCAN && word_reg == $past(word_reg) + AW'(1)), "scan did not advance")

endmodule

@@ src/bitmap_first_free_allocator_unit.sv @@
// Top level of the bitmap first-free allocator with its output register.
//
// Usage: requests enter on the s_* stream, one command each (allocate the lowest
// free entry, write one bit, read one bit); every request gives exactly one result
// on the m_* stream. The cfg channel sets the active entry count (reset 4096);
// write it only while no request is in flight. cfg_ready is always high.
// A read or write passes from EXEC through ACCESS to DONE and then into the output
// register; a request rejected up front (index out of range, or allocate with a zero
// count) goes from EXEC straight to DONE; an allocate goes from EXEC to SCAN, stays
// there for each bitmap word scanned, up to MAP_BITS / WORD_BITS words, then DONE.
// The scan reads one word per cycle from the read port of the word memory.
// One request is handled at a time; s_tready rises again as the previous result
// reaches the output register, with the sequencer back in its idle state.
// After reset the bitmap memory is cleared one word per cycle, all MAP_BITS / WORD_BITS
// words in turn; s_tready stays low during that pass.
// A stalled receiver holds the result in the output register; one more request can
// complete into the sequencer behind it before s_tready drops.
module bitmap_first_free_allocator_unit #(
    parameter int MAP_BITS  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write: active entry count.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]     cfg_data,
    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [1:0], bit_index [13:2], bit_value [14], zero [15]
    input  logic [bfa_pkg::S_DATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], entry_index [13:2], bit_read [14], zero [15]
    output logic [bfa_pkg::M_DATA_W-1:0]  m_tdata
);

    import bfa_pkg::*;

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [CFG_W-1:0]     active_count_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;

    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Active count register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= ACTIVE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_count_reg <= cfg_data;
        end
    end

    // Command sequencer.
    bfa_ctrl #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_count (active_count_reg),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .command      (s_tdata[1:0]),
        .bit_index    (s_tdata[13:2]),
        .bit_value    (s_tdata[14]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // Bitmap word memory.
    bfa_mem #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register between the sequencer and the result stream.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule
